### sv/kalman_angle_bias_filter_assert.svh
// Assertion macros shared by the filter block.
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define KAB_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("kab assertion failed");
`define KAB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("kab assertion failed");
`define KAB_ASSERT_NEVER(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
    else $error("kab assertion failed");
`else
`define KAB_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define KAB_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`define KAB_ASSERT_NEVER(lbl, ck, rn, expr)
`endif
`endif

### sv/kab_pkg.sv
// Types, constants and arithmetic helpers of the angle and bias filter.
`timescale 1ns / 1ps
package kab_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DT_W      = 24;
  localparam int unsigned NOISE_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_W     = 33;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned SUM_W     = 36;
  localparam int unsigned Q_SHIFT   = 30;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned DIV_STEPS = DATA_W - 1;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BIAS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VAR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 3'd5;

  localparam logic [NOISE_W-1:0] VAR_RESET    = 31'd10737418;
  localparam logic [NOISE_W-1:0] ANOISE_RESET = 31'd10737;
  localparam logic [NOISE_W-1:0] BNOISE_RESET = 31'd107;
  localparam logic [NOISE_W-1:0] RNOISE_RESET = 31'd3221225;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STAT_UPDATED,
    STAT_DT_ZERO,
    STAT_S_BAD,
    STAT_RESTART
  } status_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RATE_DT,
    MUL_CBB_DT,
    MUL_CAB_DT,
    MUL_CBA_DT,
    MUL_P11_DT,
    MUL_AN_DT,
    MUL_BN_DT,
    MUL_K0_Y,
    MUL_K1_Y,
    MUL_K1_CAA,
    MUL_K1_CAB,
    MUL_K0_CAA,
    MUL_K0_CAB
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_ANG24,
    WB_P11DT,
    WB_ACC_INIT,
    WB_ACC_SUB,
    WB_ACC_ADD,
    WB_COV_PRED,
    WB_YS,
    WB_ANG30,
    WB_BIAS30,
    WB_CBA30,
    WB_CBB30,
    WB_CAA30,
    WB_CAB30
  } wb_op_t;

  typedef struct packed {
    logic    load_in;
    logic    restart;
    mul_op_t mul;
    wb_op_t  wb;
    logic    div_start;
    logic    div_sel;
    logic    out_load;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic restart_cmd;
    logic dt_zero;
    logic s_pos;
    logic div_done;
    logic div_busy;
  } dp_sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] rnd24(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) << (DT_W - 1));
    return t[DT_W+SUM_W-1:DT_W];
  endfunction

  function automatic logic signed [SUM_W-1:0] rnd30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) << (Q_SHIFT - 1));
    return t[Q_SHIFT+SUM_W-1:Q_SHIFT];
  endfunction

endpackage

### sv/kab_intf.sv
// Channel interfaces of the angle and bias filter.
`timescale 1ns / 1ps
interface kab_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [kab_pkg::DATA_W-1:0]   measured_angle;
  logic signed [kab_pkg::DATA_W-1:0]   gyro_rate;
  logic        [kab_pkg::DT_W-1:0]     time_step;
  modport source(output valid, cmd, measured_angle, gyro_rate, time_step, input ready);
  modport sink(input valid, cmd, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kab_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kab_pkg::DATA_W-1:0] angle_estimate;
  logic signed [kab_pkg::DATA_W-1:0] bias_estimate;
  logic signed [kab_pkg::DATA_W-1:0] residual;
  logic [1:0]                        status;
  modport source(output valid, angle_estimate, bias_estimate, residual, status, input ready);
  modport sink(input valid, angle_estimate, bias_estimate, residual, status, output ready);
endinterface

interface kab_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kab_pkg::CFG_IDX_W-1:0]     index;
  logic [kab_pkg::DATA_W-1:0]        data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/kab_div.sv
// Bit-serial signed gain divider with saturation, one quotient bit per cycle.
`timescale 1ns / 1ps
module kab_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [kab_pkg::DATA_W-1:0]   dividend,
  input  logic        [kab_pkg::DATA_W-1:0]   divisor,
  output logic signed [kab_pkg::DATA_W-1:0]   quot,
  output logic                                done,
  output logic                                busy
);

  logic                               busy_r;
  logic                               done_r;
  logic [kab_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic [kab_pkg::DATA_W:0]           rem_r;
  logic [kab_pkg::DATA_W-2:0]         lo_r;
  logic [kab_pkg::DATA_W-2:0]         q_r;
  logic [kab_pkg::DATA_W-1:0]         dsr_r;
  logic                               neg_r;
  logic signed [kab_pkg::DATA_W-1:0]  quot_r;

  logic [kab_pkg::DATA_W-1:0]         mag;
  logic [kab_pkg::DATA_W:0]           trial;
  logic                               qbit;
  logic [kab_pkg::DATA_W-2:0]         q_fin;
  logic signed [kab_pkg::DATA_W-1:0]  q_pos;

  always_comb begin
    mag   = dividend[kab_pkg::DATA_W-1] ? kab_pkg::DATA_W'(-dividend) : dividend;
    trial = {rem_r[kab_pkg::DATA_W-1:0], lo_r[kab_pkg::DATA_W-2]};
    qbit  = (trial >= {1'b0, dsr_r});
    q_fin = {q_r[kab_pkg::DATA_W-3:0], qbit};
    q_pos = $signed({1'b0, q_fin});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r <= dividend[kab_pkg::DATA_W-1];
        dsr_r <= divisor;
        if ({1'b0, mag} >= {divisor, 1'b0}) begin
          quot_r <= dividend[kab_pkg::DATA_W-1] ? kab_pkg::SAT_LO[kab_pkg::DATA_W-1:0]
                                                : kab_pkg::SAT_HI[kab_pkg::DATA_W-1:0];
          done_r <= 1'b1;
        end else begin
          rem_r  <= {2'b00, mag[kab_pkg::DATA_W-1:1]};
          lo_r   <= {mag[0], {(kab_pkg::DATA_W-2){1'b0}}};
          q_r    <= '0;
          cnt_r  <= kab_pkg::DIV_CNT_W'(kab_pkg::DIV_STEPS);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= qbit ? (trial - {1'b0, dsr_r}) : trial;
        lo_r  <= {lo_r[kab_pkg::DATA_W-3:0], 1'b0};
        q_r   <= q_fin;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == kab_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= neg_r ? -q_pos : q_pos;
        end
      end
    end
  end

  assign quot = quot_r;
  assign done = done_r;
  assign busy = busy_r;

endmodule

### sv/kab_datapath.sv
// Filter datapath: configuration, state, shared multiplier, divider and result register.
`timescale 1ns / 1ps
module kab_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kab_pkg::dp_cmd_t                    cmd,
  output kab_pkg::dp_sts_t                    sts,
  input  logic                                in_cmd,
  input  logic signed [kab_pkg::DATA_W-1:0]   in_measured_angle,
  input  logic signed [kab_pkg::DATA_W-1:0]   in_gyro_rate,
  input  logic        [kab_pkg::DT_W-1:0]     in_time_step,
  input  logic                                cfg_we,
  input  logic        [kab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [kab_pkg::DATA_W-1:0]   cfg_data,
  output logic signed [kab_pkg::DATA_W-1:0]   out_angle_estimate,
  output logic signed [kab_pkg::DATA_W-1:0]   out_bias_estimate,
  output logic signed [kab_pkg::DATA_W-1:0]   out_residual,
  output logic        [1:0]                   out_status
);

  localparam int unsigned DW = kab_pkg::DATA_W;
  localparam int unsigned SW = kab_pkg::SUM_W;
  localparam int unsigned MW = kab_pkg::MUL_W;
  localparam int unsigned NW = kab_pkg::NOISE_W;

  logic signed [DW-1:0]            start_angle_r, start_bias_r;
  logic        [NW-1:0]            start_var_r, angle_noise_r, bias_noise_r, meas_noise_r;
  logic signed [DW-1:0]            ang_r, bias_r, caa_r, cab_r, cba_r, cbb_r;
  logic                            cmd_r;
  logic signed [DW-1:0]            meas_r, rate_r, p11dt_r, y_r, k0_r, k1_r;
  logic        [kab_pkg::DT_W-1:0] dt_r;
  logic signed [SW-1:0]            acc_r;
  logic signed [MW-1:0]            s_r;
  logic signed [kab_pkg::PROD_W-1:0] prod_r;
  logic                            div_sel_r;
  logic signed [DW-1:0]            oang_r, obias_r, ores_r;
  logic        [1:0]               ostat_r;

  logic signed [MW-1:0]            mul_a, mul_b, dt_ext;
  logic signed [SW-1:0]            r24, r30;
  logic signed [DW-1:0]            div_q;
  logic                            div_done, div_busy;

  always_comb begin
    dt_ext = $signed({{(MW-kab_pkg::DT_W){1'b0}}, dt_r});
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.mul)
      kab_pkg::MUL_RATE_DT: begin mul_a = MW'(rate_r);  mul_b = dt_ext; end
      kab_pkg::MUL_CBB_DT:  begin mul_a = MW'(cbb_r);   mul_b = dt_ext; end
      kab_pkg::MUL_CAB_DT:  begin mul_a = MW'(cab_r);   mul_b = dt_ext; end
      kab_pkg::MUL_CBA_DT:  begin mul_a = MW'(cba_r);   mul_b = dt_ext; end
      kab_pkg::MUL_P11_DT:  begin mul_a = MW'(p11dt_r); mul_b = dt_ext; end
      kab_pkg::MUL_AN_DT: begin
        mul_a = $signed({{(MW-NW){1'b0}}, angle_noise_r});
        mul_b = dt_ext;
      end
      kab_pkg::MUL_BN_DT: begin
        mul_a = $signed({{(MW-NW){1'b0}}, bias_noise_r});
        mul_b = dt_ext;
      end
      kab_pkg::MUL_K0_Y:   begin mul_a = MW'(k0_r); mul_b = MW'(y_r);   end
      kab_pkg::MUL_K1_Y:   begin mul_a = MW'(k1_r); mul_b = MW'(y_r);   end
      kab_pkg::MUL_K1_CAA: begin mul_a = MW'(k1_r); mul_b = MW'(caa_r); end
      kab_pkg::MUL_K1_CAB: begin mul_a = MW'(k1_r); mul_b = MW'(cab_r); end
      kab_pkg::MUL_K0_CAA: begin mul_a = MW'(k0_r); mul_b = MW'(caa_r); end
      kab_pkg::MUL_K0_CAB: begin mul_a = MW'(k0_r); mul_b = MW'(cab_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    r24 = kab_pkg::rnd24(prod_r);
    r30 = kab_pkg::rnd30(prod_r);
  end

  kab_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? cba_r : caa_r),
    .divisor  (s_r[DW-1:0]),
    .quot     (div_q),
    .done     (div_done),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load_in) begin
      cmd_r  <= in_cmd;
      meas_r <= in_measured_angle;
      dt_r   <= in_time_step;
      rate_r <= kab_pkg::sat32(SW'(in_gyro_rate) - SW'(bias_r));
    end
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
    end
    if (div_done) begin
      if (div_sel_r) begin
        k1_r <= div_q;
      end else begin
        k0_r <= div_q;
      end
    end
    case (cmd.wb)
      kab_pkg::WB_P11DT:    p11dt_r <= r24[DW-1:0];
      kab_pkg::WB_ACC_INIT: acc_r <= SW'(caa_r) - r24;
      kab_pkg::WB_ACC_SUB:  acc_r <= acc_r - r24;
      kab_pkg::WB_ACC_ADD:  acc_r <= acc_r + r24;
      kab_pkg::WB_YS: begin
        y_r <= kab_pkg::sat32(SW'(meas_r) - SW'(ang_r));
        s_r <= MW'(caa_r) + $signed({{(MW-NW){1'b0}}, meas_noise_r});
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      ostat_r <= cmd.code;
      obias_r <= bias_r;
      oang_r  <= (cmd.code == kab_pkg::STAT_DT_ZERO) ? '0 : ang_r;
      ores_r  <= (cmd.code == kab_pkg::STAT_UPDATED || cmd.code == kab_pkg::STAT_S_BAD)
                 ? y_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      start_bias_r  <= '0;
      start_var_r   <= kab_pkg::VAR_RESET;
      angle_noise_r <= kab_pkg::ANOISE_RESET;
      bias_noise_r  <= kab_pkg::BNOISE_RESET;
      meas_noise_r  <= kab_pkg::RNOISE_RESET;
      ang_r         <= '0;
      bias_r        <= '0;
      caa_r         <= $signed({1'b0, kab_pkg::VAR_RESET});
      cab_r         <= '0;
      cba_r         <= '0;
      cbb_r         <= $signed({1'b0, kab_pkg::VAR_RESET});
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kab_pkg::CFG_START_ANGLE:   start_angle_r <= cfg_data;
          kab_pkg::CFG_START_BIAS:    start_bias_r  <= cfg_data;
          kab_pkg::CFG_START_VAR:     start_var_r   <= cfg_data[NW-1:0];
          kab_pkg::CFG_ANGLE_NOISE:   angle_noise_r <= cfg_data[NW-1:0];
          kab_pkg::CFG_BIAS_NOISE:    bias_noise_r  <= cfg_data[NW-1:0];
          kab_pkg::CFG_MEASURE_NOISE: meas_noise_r  <= cfg_data[NW-1:0];
          default: ;
        endcase
      end
      if (cmd.restart) begin
        ang_r  <= start_angle_r;
        bias_r <= start_bias_r;
        caa_r  <= $signed({1'b0, start_var_r});
        cbb_r  <= $signed({1'b0, start_var_r});
        cab_r  <= '0;
        cba_r  <= '0;
      end
      case (cmd.wb)
        kab_pkg::WB_ANG24: ang_r <= kab_pkg::sat32(SW'(ang_r) + r24);
        kab_pkg::WB_COV_PRED: begin
          caa_r <= kab_pkg::sat32(acc_r);
          cab_r <= kab_pkg::sat32(SW'(cab_r) - SW'(p11dt_r));
          cba_r <= kab_pkg::sat32(SW'(cba_r) - SW'(p11dt_r));
          cbb_r <= kab_pkg::sat32(SW'(cbb_r) + r24);
        end
        kab_pkg::WB_ANG30:  ang_r  <= kab_pkg::sat32(SW'(ang_r) + r30);
        kab_pkg::WB_BIAS30: bias_r <= kab_pkg::sat32(SW'(bias_r) + r30);
        kab_pkg::WB_CBA30:  cba_r  <= kab_pkg::sat32(SW'(cba_r) - r30);
        kab_pkg::WB_CBB30:  cbb_r  <= kab_pkg::sat32(SW'(cbb_r) - r30);
        kab_pkg::WB_CAA30:  caa_r  <= kab_pkg::sat32(SW'(caa_r) - r30);
        kab_pkg::WB_CAB30:  cab_r  <= kab_pkg::sat32(SW'(cab_r) - r30);
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.restart_cmd = cmd_r;
    sts.dt_zero     = (dt_r == '0);
    sts.s_pos       = !s_r[MW-1] && (s_r != '0);
    sts.div_done    = div_done;
    sts.div_busy    = div_busy;
  end

  assign out_angle_estimate = oang_r;
  assign out_bias_estimate  = obias_r;
  assign out_residual       = ores_r;
  assign out_status         = ostat_r;

endmodule

### sv/kab_ctrl.sv
// Filter sequencer: steps the datapath through predict, gain division and correction.
`timescale 1ns / 1ps
module kab_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  kab_pkg::dp_sts_t sts,
  output kab_pkg::dp_cmd_t cmd
);

  localparam logic [kab_pkg::STEP_W-1:0] PRED_LAST = 4'd8;
  localparam logic [kab_pkg::STEP_W-1:0] CORR_LAST = 4'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_PRED, ST_CHK, ST_DIV0, ST_WAIT0,
    ST_DIV1, ST_WAIT1, ST_CORR, ST_FIN
  } state_t;

  state_t                        state_r, state_nxt;
  logic [kab_pkg::STEP_W-1:0]    step_r, step_nxt;
  kab_pkg::status_t              code_r, code_nxt;
  logic                          out_valid_r, out_valid_nxt;

  function automatic kab_pkg::mul_op_t pred_mul(input logic [kab_pkg::STEP_W-1:0] s);
    kab_pkg::mul_op_t m;
    case (s)
      4'd0:    m = kab_pkg::MUL_RATE_DT;
      4'd1:    m = kab_pkg::MUL_CBB_DT;
      4'd2:    m = kab_pkg::MUL_CAB_DT;
      4'd3:    m = kab_pkg::MUL_CBA_DT;
      4'd4:    m = kab_pkg::MUL_P11_DT;
      4'd5:    m = kab_pkg::MUL_AN_DT;
      4'd6:    m = kab_pkg::MUL_BN_DT;
      default: m = kab_pkg::MUL_NONE;
    endcase
    return m;
  endfunction

  function automatic kab_pkg::wb_op_t pred_wb(input logic [kab_pkg::STEP_W-1:0] s);
    kab_pkg::wb_op_t w;
    case (s)
      4'd1:    w = kab_pkg::WB_ANG24;
      4'd2:    w = kab_pkg::WB_P11DT;
      4'd3:    w = kab_pkg::WB_ACC_INIT;
      4'd4:    w = kab_pkg::WB_ACC_SUB;
      4'd5:    w = kab_pkg::WB_ACC_ADD;
      4'd6:    w = kab_pkg::WB_ACC_ADD;
      4'd7:    w = kab_pkg::WB_COV_PRED;
      4'd8:    w = kab_pkg::WB_YS;
      default: w = kab_pkg::WB_NONE;
    endcase
    return w;
  endfunction

  function automatic kab_pkg::mul_op_t corr_mul(input logic [kab_pkg::STEP_W-1:0] s);
    kab_pkg::mul_op_t m;
    case (s)
      4'd0:    m = kab_pkg::MUL_K0_Y;
      4'd1:    m = kab_pkg::MUL_K1_Y;
      4'd2:    m = kab_pkg::MUL_K1_CAA;
      4'd3:    m = kab_pkg::MUL_K1_CAB;
      4'd4:    m = kab_pkg::MUL_K0_CAA;
      4'd5:    m = kab_pkg::MUL_K0_CAB;
      default: m = kab_pkg::MUL_NONE;
    endcase
    return m;
  endfunction

  function automatic kab_pkg::wb_op_t corr_wb(input logic [kab_pkg::STEP_W-1:0] s);
    kab_pkg::wb_op_t w;
    case (s)
      4'd1:    w = kab_pkg::WB_ANG30;
      4'd2:    w = kab_pkg::WB_BIAS30;
      4'd3:    w = kab_pkg::WB_CBA30;
      4'd4:    w = kab_pkg::WB_CBB30;
      4'd5:    w = kab_pkg::WB_CAA30;
      4'd6:    w = kab_pkg::WB_CAB30;
      default: w = kab_pkg::WB_NONE;
    endcase
    return w;
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.code      = code_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts.restart_cmd) begin
          cmd.restart = 1'b1;
          code_nxt    = kab_pkg::STAT_RESTART;
          state_nxt   = ST_FIN;
        end else if (sts.dt_zero) begin
          code_nxt  = kab_pkg::STAT_DT_ZERO;
          state_nxt = ST_FIN;
        end else begin
          step_nxt  = '0;
          state_nxt = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.mul = pred_mul(step_r);
        cmd.wb  = pred_wb(step_r);
        if (step_r == PRED_LAST) begin
          state_nxt = ST_CHK;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_CHK: begin
        if (sts.s_pos) begin
          state_nxt = ST_DIV0;
        end else begin
          code_nxt  = kab_pkg::STAT_S_BAD;
          state_nxt = ST_FIN;
        end
      end
      ST_DIV0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b0;
        state_nxt     = ST_WAIT0;
      end
      ST_WAIT0: begin
        if (sts.div_done) begin
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (sts.div_done) begin
          step_nxt  = '0;
          state_nxt = ST_CORR;
        end
      end
      ST_CORR: begin
        cmd.mul = corr_mul(step_r);
        cmd.wb  = corr_wb(step_r);
        if (step_r == CORR_LAST) begin
          code_nxt  = kab_pkg::STAT_UPDATED;
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      code_r      <= kab_pkg::STAT_UPDATED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/kalman_angle_bias_filter.sv
// Channel      Dir  Beat contents
// in_bus       in   cmd, measured_angle, gyro_rate, time_step
// out_bus      out  angle_estimate, bias_estimate, residual, status
// cfg_bus      in   index, data (always ready)
// A filter update steps through prediction, two bit-serial gain divisions and correction;
// each gain division ends early when its quotient saturates, and the shared multiplier
// registers each product. Restart and zero time step beats skip straight to the result.
// The next input beat is taken once the result sits in the output register.
// Reset is synchronous and restores the configuration and filter state defaults.
`timescale 1ns / 1ps
`include "kalman_angle_bias_filter_assert.svh"
module kalman_angle_bias_filter (
  input logic        clk,
  input logic        rst_n,
  kab_in_if.sink     in_bus,
  kab_out_if.source  out_bus,
  kab_cfg_if.sink    cfg_bus
);

  kab_pkg::dp_cmd_t cmd;
  kab_pkg::dp_sts_t sts;
  logic             in_ready;
  logic             out_valid;

  kab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kab_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_cmd             (in_bus.cmd),
    .in_measured_angle  (in_bus.measured_angle),
    .in_gyro_rate       (in_bus.gyro_rate),
    .in_time_step       (in_bus.time_step),
    .cfg_we             (cfg_bus.valid),
    .cfg_index          (cfg_bus.index),
    .cfg_data           (cfg_bus.data),
    .out_angle_estimate (out_bus.angle_estimate),
    .out_bias_estimate  (out_bus.bias_estimate),
    .out_residual       (out_bus.residual),
    .out_status         (out_bus.status)
  );

  assign in_bus.ready  = in_ready;
  assign out_bus.valid = out_valid;
  assign cfg_bus.ready = 1'b1;

  `KAB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_bus.valid && in_ready, !in_ready)
  `KAB_ASSERT_NEVER(a_div_restart, clk, rst_n, cmd.div_start && sts.div_busy)
  `KAB_ASSERT_IMP(a_div_needs_pos_s, clk, rst_n, cmd.div_start, sts.s_pos)
  `KAB_ASSERT_NEVER(a_out_overwrite, clk, rst_n, cmd.out_load && out_valid && !out_bus.ready)

endmodule

### dv/kab_checker.sv
// Monitor, state predictor and scoreboard for the angle and bias filter.
`timescale 1ns / 1ps
module kab_checker (
  input  logic clk,
  input  logic rst_n,
  kab_in_if    in_bus,
  kab_out_if   out_bus,
  kab_cfg_if   cfg_bus,
  output int   mismatch_count,
  output int   pending_count
);

  typedef struct {
    longint           angle;
    longint           bias;
    longint           resid;
    kab_pkg::status_t status;
  } estimate_t;

  estimate_t expected_q[$];

  longint start_angle_r, start_bias_r, start_var_r, angle_noise_r, bias_noise_r, meas_noise_r;
  longint ang_s, bias_s, p_aa, p_ab, p_ba, p_bb;

  assign pending_count = expected_q.size();

  initial mismatch_count = 0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(input longint x, input int sh);
    longint t;
    t = x + (64'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

  task automatic reload_state();
    ang_s = start_angle_r;
    bias_s = start_bias_r;
    p_aa = start_var_r;
    p_bb = start_var_r;
    p_ab = 0;
    p_ba = 0;
  endtask

  task automatic filter_step(input logic cmd, input longint meas, input longint gyro,
                             input longint dt, output estimate_t e);
    longint rate, p00, p01, p10, p11, p11dt, y, s, k0, k1;
    if (cmd) begin
      reload_state();
      e = '{ang_s, bias_s, 0, kab_pkg::STAT_RESTART};
      return;
    end
    if (dt == 0) begin
      e = '{0, bias_s, 0, kab_pkg::STAT_DT_ZERO};
      return;
    end
    rate = clamp32(gyro - bias_s);
    ang_s = clamp32(ang_s + round_shift(rate * dt, kab_pkg::DT_W));
    p11dt = round_shift(p_bb * dt, kab_pkg::DT_W);
    p00 = p_aa - round_shift(p_ab * dt, kab_pkg::DT_W) - round_shift(p_ba * dt, kab_pkg::DT_W)
        + round_shift(p11dt * dt, kab_pkg::DT_W)
        + round_shift(angle_noise_r * dt, kab_pkg::DT_W);
    p01 = p_ab - p11dt;
    p10 = p_ba - p11dt;
    p11 = p_bb + round_shift(bias_noise_r * dt, kab_pkg::DT_W);
    p_aa = clamp32(p00);
    p_ab = clamp32(p01);
    p_ba = clamp32(p10);
    p_bb = clamp32(p11);
    y = clamp32(meas - ang_s);
    s = p_aa + meas_noise_r;
    if (s <= 0) begin
      e = '{ang_s, bias_s, y, kab_pkg::STAT_S_BAD};
      return;
    end
    k0 = clamp32((p_aa * (64'sd1 <<< kab_pkg::Q_SHIFT)) / s);
    k1 = clamp32((p_ba * (64'sd1 <<< kab_pkg::Q_SHIFT)) / s);
    ang_s = clamp32(ang_s + round_shift(k0 * y, kab_pkg::Q_SHIFT));
    bias_s = clamp32(bias_s + round_shift(k1 * y, kab_pkg::Q_SHIFT));
    p00 = p_aa;
    p01 = p_ab;
    p_aa = clamp32(p00 - round_shift(k0 * p00, kab_pkg::Q_SHIFT));
    p_ab = clamp32(p01 - round_shift(k0 * p01, kab_pkg::Q_SHIFT));
    p_ba = clamp32(p_ba - round_shift(k1 * p00, kab_pkg::Q_SHIFT));
    p_bb = clamp32(p_bb - round_shift(k1 * p01, kab_pkg::Q_SHIFT));
    e = '{ang_s, bias_s, y, kab_pkg::STAT_UPDATED};
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    estimate_t e;
    if (!rst_n) begin
      start_angle_r = 0;
      start_bias_r = 0;
      start_var_r = kab_pkg::VAR_RESET;
      angle_noise_r = kab_pkg::ANOISE_RESET;
      bias_noise_r = kab_pkg::BNOISE_RESET;
      meas_noise_r = kab_pkg::RNOISE_RESET;
      reload_state();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          kab_pkg::CFG_START_ANGLE:   start_angle_r = longint'($signed(cfg_bus.data));
          kab_pkg::CFG_START_BIAS:    start_bias_r = longint'($signed(cfg_bus.data));
          kab_pkg::CFG_START_VAR:
            start_var_r = longint'(cfg_bus.data[kab_pkg::NOISE_W-1:0]);
          kab_pkg::CFG_ANGLE_NOISE:
            angle_noise_r = longint'(cfg_bus.data[kab_pkg::NOISE_W-1:0]);
          kab_pkg::CFG_BIAS_NOISE:
            bias_noise_r = longint'(cfg_bus.data[kab_pkg::NOISE_W-1:0]);
          kab_pkg::CFG_MEASURE_NOISE:
            meas_noise_r = longint'(cfg_bus.data[kab_pkg::NOISE_W-1:0]);
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        filter_step(in_bus.cmd, longint'($signed(in_bus.measured_angle)),
                    longint'($signed(in_bus.gyro_rate)), longint'(in_bus.time_step), e);
        expected_q.push_back(e);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat status", out_bus.status, -1);
        end else begin
          e = expected_q.pop_front();
          if (longint'($signed(out_bus.angle_estimate)) != e.angle)
            report_mismatch("angle_estimate", $signed(out_bus.angle_estimate), e.angle);
          if (longint'($signed(out_bus.bias_estimate)) != e.bias)
            report_mismatch("bias_estimate", $signed(out_bus.bias_estimate), e.bias);
          if (longint'($signed(out_bus.residual)) != e.resid)
            report_mismatch("residual", $signed(out_bus.residual), e.resid);
          if (out_bus.status != e.status)
            report_mismatch("status", out_bus.status, e.status);
        end
      end
    end
  end
endmodule

### dv/kalman_angle_bias_filter_tb.sv
// Stimulus and verdict for the angle and bias filter, checked by kab_checker.
`timescale 1ns / 1ps
module kalman_angle_bias_filter_tb;

  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam int   SETTLE_CYCLES = 120;
  localparam logic [kab_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [kab_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   mismatch_count;
  int   pending_count;
  int   beats_sent;
  int   restarts_sent;
  int   cfg_writes;

  kab_in_if  in_bus();
  kab_out_if out_bus();
  kab_cfg_if cfg_bus();

  kalman_angle_bias_filter DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  kab_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n;
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready = 1'b0;
        n = $urandom_range(1, 19);
      end else begin
        out_bus.ready = 1'b1;
        n = $urandom_range(1, 30);
      end
      repeat (n) @(negedge clk);
    end
  end

  task automatic send_beat(input logic cmd, input logic [31:0] meas, input logic [31:0] gyro,
                           input logic [23:0] dt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.cmd = cmd;
    in_bus.measured_angle = meas;
    in_bus.gyro_rate = gyro;
    in_bus.time_step = dt;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    in_bus.valid = 1'b0;
    beats_sent++;
    if (cmd == CMD_RESTART) restarts_sent++;
  endtask

  task automatic write_reg(input logic [kab_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [31:0] pick_signed();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 20000))};
      3: return 32'(kab_pkg::VAR_RESET) ^ ($urandom & 32'h8000_00FF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_dt();
    case ($urandom_range(0, 9))
      0: return 24'h0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(1, 40000));
    endcase
  endfunction

  initial begin
    int phase;
    int wait_cycles;
    logic [31:0] meas;
    rst_n = 1'b0;
    idle_on = 1'b1;
    beats_sent = 0;
    restarts_sent = 0;
    cfg_writes = 0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_UPDATE;
    in_bus.measured_angle = '0;
    in_bus.gyro_rate = '0;
    in_bus.time_step = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = kab_pkg::CFG_START_ANGLE;
    cfg_bus.data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed beats with the reset configuration.
    send_beat(CMD_UPDATE, 32'h0001_0000, 32'h0000_8000, 24'd10000);
    send_beat(CMD_UPDATE, 32'h0, 32'h0, 24'h0);
    send_beat(CMD_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_beat(CMD_UPDATE, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
    send_beat(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
    send_beat(CMD_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_beat(CMD_UPDATE, 32'hFFFF_0000, 32'h0002_0000, 24'd16777);
    send_beat(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 24'h0);

    // Zero variance and noise make the denominator zero.
    write_reg(kab_pkg::CFG_START_VAR, 32'h0);
    write_reg(kab_pkg::CFG_ANGLE_NOISE, 32'h0);
    write_reg(kab_pkg::CFG_MEASURE_NOISE, 32'h0);
    write_reg(kab_pkg::CFG_START_ANGLE, 32'h7FFF_FFFF);
    write_reg(kab_pkg::CFG_START_BIAS, 32'h8000_0000);
    write_reg(kab_pkg::CFG_BIAS_NOISE, 32'h7FFF_FFFF);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'h1234_5678);
    send_beat(CMD_RESTART, 32'h0, 32'h0, 24'h0);
    send_beat(CMD_UPDATE, 32'h1234_5678, 32'h7FFF_FFFF, 24'd500);
    send_beat(CMD_UPDATE, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
    send_beat(CMD_UPDATE, 32'h0, 32'h0, 24'd1);

    // Extreme variance and noise drive the covariance into saturation.
    write_reg(kab_pkg::CFG_START_VAR, 32'hFFFF_FFFF);
    write_reg(kab_pkg::CFG_ANGLE_NOISE, 32'h7FFF_FFFF);
    write_reg(kab_pkg::CFG_MEASURE_NOISE, 32'h7FFF_FFFF);
    send_beat(CMD_RESTART, 32'h0, 32'h0, 24'h0);
    send_beat(CMD_UPDATE, 32'h8000_0000, 32'h0, 24'hFF_FFFF);
    send_beat(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    send_beat(CMD_UPDATE, 32'h0, 32'h7FFF_FFFF, 24'd77);

    for (phase = 0; phase < 9; phase++) begin
      write_reg(kab_pkg::CFG_START_ANGLE, pick_signed());
      write_reg(kab_pkg::CFG_START_BIAS, pick_signed());
      write_reg(kab_pkg::CFG_START_VAR, pick_noise());
      write_reg(kab_pkg::CFG_ANGLE_NOISE, pick_noise());
      write_reg(kab_pkg::CFG_BIAS_NOISE, pick_noise());
      write_reg(kab_pkg::CFG_MEASURE_NOISE,
                phase == 0 ? 32'(kab_pkg::RNOISE_RESET) : pick_noise());
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
      send_beat(CMD_RESTART, $urandom, $urandom, 24'($urandom));
      if (phase == 8) idle_on = 1'b0;
      repeat (146) begin
        if ($urandom_range(0, 19) == 0) begin
          send_beat(CMD_RESTART, $urandom, $urandom, 24'($urandom));
        end else begin
          meas = ($urandom_range(0, 2) == 0) ? $urandom : pick_signed();
          send_beat(CMD_UPDATE, meas, pick_signed(), pick_dt());
        end
      end
    end

    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d input beats (%0d restarts) over %0d register writes.",
             beats_sent, restarts_sent, cfg_writes);
    $display("Configurations ranged over zero, full scale and random noise and start values.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/kab_pkg.sv
sv/kab_intf.sv
sv/kab_div.sv
sv/kab_datapath.sv
sv/kab_ctrl.sv
sv/kalman_angle_bias_filter.sv
dv/kab_checker.sv
dv/kalman_angle_bias_filter_tb.sv
